// ----- src/aes_pkg.sv -----
// shared types, constants and round functions for the aes-128 encrypt pipeline
package aes_pkg;

  localparam int ROUNDS = 10;
  localparam int BLOCK_W = 128;
  localparam int HALF_W = 64;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  // data handed from one cell to the next: round state and round key
  typedef struct packed {
    logic [BLOCK_W-1:0] state;
    logic [BLOCK_W-1:0] key;
  } blk_t;

  localparam logic [7:0] RCON [ROUNDS+1] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] v, input int i);
    return v[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes and shiftrows: row r of column c takes row r of column c+r
  function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    return t;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      t[BLOCK_W-1-8*(4*c)   -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[BLOCK_W-1-8*(4*c+3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    return t;
  endfunction

  // one step of the key schedule: four new words from the previous four
  function automatic logic [BLOCK_W-1:0] next_key(input logic [BLOCK_W-1:0] k,
                                                  input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// ----- src/aes_round_cell.sv -----
// one round cell: expands the next round key and runs one cipher round
module aes_round_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  aes_pkg::blk_t     up_blk,
  input  logic [7:0]        rcon,
  input  logic              final_round,
  output logic              down_valid,
  input  logic              down_ready,
  output aes_pkg::blk_t     down_blk
);

  logic [aes_pkg::BLOCK_W-1:0] shifted;
  logic [aes_pkg::BLOCK_W-1:0] mixed;
  logic [aes_pkg::BLOCK_W-1:0] round_key;
  aes_pkg::blk_t               blk_next;

  // cell takes a new item when empty or when its own item moves on
  assign up_ready = !down_valid || down_ready;

  always_comb begin
    shifted = aes_pkg::sub_shift(up_blk.state);
    mixed = final_round ? shifted : aes_pkg::mix_cols(shifted);
    round_key = aes_pkg::next_key(up_blk.key, rcon);
    blk_next.state = mixed ^ round_key;
    blk_next.key = round_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_blk <= blk_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    down_valid && !down_ready |=> down_valid && $stable(down_blk))
    else $error("round cell dropped or changed a blocked item");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready |=> down_valid)
    else $error("round cell lost an accepted item");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    down_valid && down_ready && !up_valid |=> !down_valid)
    else $error("round cell repeated an item");

  a_busy_means_full: assert property (@(posedge clk) disable iff (rst)
    !up_ready |-> down_valid)
    else $error("round cell refused an item while empty");
`endif

endmodule

// ----- src/aes128_block_encrypt.sv -----
// aes-128 block encrypt: key registers, add-key entry stage and a chain of round cells
//
//   channel   dir   handshake              payload
//   in        in    in_valid / in_stall    plain_high, plain_low
//   out       out   out_valid / out_stall  cipher_high, cipher_low
//   cfg       in    cfg_write              cfg_index, cfg_data
//
// the pipeline is one add-key entry stage and ten round cells
// one item per cycle sustained while out is not stalled; each cell holds one item and its round key
// a stall on out holds only full cells; empty cells upstream keep filling
// rst clears all cell valid bits and the key registers to zero

module aes128_block_encrypt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [aes_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [aes_pkg::HALF_W-1:0]          plain_high,
  input  logic [aes_pkg::HALF_W-1:0]          plain_low,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [aes_pkg::HALF_W-1:0]          cipher_high,
  output logic [aes_pkg::HALF_W-1:0]          cipher_low
);

  logic [aes_pkg::HALF_W-1:0] key_high;
  logic [aes_pkg::HALF_W-1:0] key_low;

  logic          entry_valid;
  aes_pkg::blk_t entry_blk;

  logic          stage_valid [aes_pkg::ROUNDS+1];
  logic          stage_ready [aes_pkg::ROUNDS+2];
  aes_pkg::blk_t stage_blk   [aes_pkg::ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_write) begin
      unique case (aes_pkg::cfg_reg_t'(cfg_index))
        aes_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        aes_pkg::REG_KEY_LOW:  key_low <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage: initial add-key, carries the cipher key along
  assign stage_ready[0] = !entry_valid || stage_ready[1];
  assign in_stall = !stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (stage_ready[0]) begin
      entry_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0] && in_valid) begin
      entry_blk.state <= {plain_high, plain_low} ^ {key_high, key_low};
      entry_blk.key <= {key_high, key_low};
    end
  end

  assign stage_valid[0] = entry_valid;
  assign stage_blk[0] = entry_blk;

  for (genvar i = 1; i <= aes_pkg::ROUNDS; i++) begin : g_round
    aes_round_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .up_valid    (stage_valid[i-1]),
      .up_ready    (stage_ready[i]),
      .up_blk      (stage_blk[i-1]),
      .rcon        (aes_pkg::RCON[i]),
      .final_round (1'(i == aes_pkg::ROUNDS)),
      .down_valid  (stage_valid[i]),
      .down_ready  (stage_ready[i+1]),
      .down_blk    (stage_blk[i])
    );
  end

  assign stage_ready[aes_pkg::ROUNDS+1] = !out_stall;
  assign out_valid = stage_valid[aes_pkg::ROUNDS];
  assign cipher_high = stage_blk[aes_pkg::ROUNDS].state[aes_pkg::BLOCK_W-1 -: aes_pkg::HALF_W];
  assign cipher_low = stage_blk[aes_pkg::ROUNDS].state[aes_pkg::HALF_W-1:0];

endmodule
